[rtl/core/mcst_pkg.sv]
// Package for the multi-channel soft timer: sizes, operation and state codes,
// slot table entry layout. No dependencies.
`default_nettype none
package mcst_pkg;

  localparam int TIMERS      = 8;
  localparam int TICK_MS     = 10;
  localparam int MAX_RESULTS = 8;

  localparam int OP_W     = 4;
  localparam int SLOT_W   = 7;
  localparam int PMS_W    = 32;
  localparam int PER_W    = 29;
  localparam int REM_MS_W = 33;
  localparam int TICK_W   = 32;

  localparam int IDX_W  = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CNT_W  = $clog2(TIMERS + 1);
  localparam int REP_W  = $clog2(MAX_RESULTS + 1);
  // Dividend for the rounded-up conversion is interval_ms + TICK_MS - 1.
  localparam int DIVD_W = PMS_W + 1;

  // Exact floor divide by TICK_MS for any DIVD_W-bit dividend:
  // q = (x * REC_MUL) >> REC_SH, REC_MUL = ceil(2^REC_SH / TICK_MS).
  localparam int REC_SH   = DIVD_W + $clog2(TICK_MS);
  localparam int REC_W    = DIVD_W + 1;
  localparam int REC_HALF = (REC_W + 1) / 2;
  localparam int PART_W   = DIVD_W + REC_HALF;
  localparam int PROD_W   = DIVD_W + 2 * REC_HALF;
  localparam longint unsigned REC_MUL =
    ((64'd1 << REC_SH) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
  localparam logic [REC_HALF-1:0] REC_LO = REC_HALF'(REC_MUL);
  localparam logic [REC_HALF-1:0] REC_HI = REC_HALF'(REC_MUL >> REC_HALF);

  typedef enum logic [OP_W-1:0] {
    OP_TICK          = 4'd0,
    OP_CREATE        = 4'd1,
    OP_DESTROY       = 4'd2,
    OP_START         = 4'd3,
    OP_STOP          = 4'd4,
    OP_PAUSE         = 4'd5,
    OP_RESUME        = 4'd6,
    OP_SET_PERIOD    = 4'd7,
    OP_GET_STATE     = 4'd8,
    OP_GET_REMAINING = 4'd9,
    OP_GET_TICKS     = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    RS_STOPPED = 2'd0,
    RS_RUNNING = 2'd1,
    RS_PAUSED  = 2'd2
  } run_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SLOT_RD,
    ST_SLOT_OP,
    ST_TICK_SCAN,
    ST_TICK_DONE
  } fsm_t;

  typedef struct packed {
    logic             mode;
    logic [1:0]       run_state;
    logic [PER_W-1:0] period;
    logic [PER_W-1:0] remaining;
  } slot_entry_t;

endpackage
`default_nettype wire

[rtl/core/multi_channel_soft_timer_unit.sv]
// Multi-channel soft timer: slot table in a synchronous RAM, command FSM,
// two-step reciprocal ms-to-tick converter. Depends on mcst_pkg.
//
// Steps to the last result: read, modify/write and output register for the slot ops
//   and get_ticks; create and set_period first take two multiply steps by 1/TICK_MS;
//   tick scans the table one slot per cycle, then emits its final result.
// Throughput: one transaction at a time; busy drops as the last result is registered, so
//   the next is taken at the edge that ends that strobe. Results cannot be stalled.
// Reset: synchronous; clears in-use marks, FSM and tick counter; the RAM is gated by them.
`default_nettype none
module multi_channel_soft_timer_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output      logic                            busy,
  input  wire logic [mcst_pkg::OP_W-1:0]       operation,
  input  wire logic [mcst_pkg::SLOT_W-1:0]     handle,
  input  wire logic                            mode,
  input  wire logic [mcst_pkg::PMS_W-1:0]      interval_ms,
  output      logic                            done,
  output      logic                            ok,
  output      logic [mcst_pkg::SLOT_W-1:0]     slot,
  output      logic                            expired,
  output      logic [1:0]                      timer_state,
  output      logic [mcst_pkg::REM_MS_W-1:0]   remaining_ms,
  output      logic [mcst_pkg::TICK_W-1:0]     tick_total,
  output      logic                            last
);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  mcst_pkg::fsm_t state, state_next;

  // Captured command
  mcst_pkg::op_t                 op_reg;
  logic [mcst_pkg::SLOT_W-1:0]   handle_reg;
  logic                          mode_reg;

  // In-use marks live in flops: they reset at once and drive the free search.
  logic [mcst_pkg::TIMERS-1:0]   in_use;
  logic [mcst_pkg::TICK_W-1:0]   tick_count;

  // Reciprocal divide: high half product first, then shift and add the low half.
  logic [mcst_pkg::DIVD_W-1:0]   div_x;
  logic                          div_phase;
  logic [mcst_pkg::REC_HALF-1:0] div_coef;
  logic [mcst_pkg::PART_W-1:0]   div_part;
  logic [mcst_pkg::PROD_W-1:0]   div_prod;

  // Tick scan: cnt is the read index, cnt-1 the slot whose data is back.
  logic [mcst_pkg::CNT_W-1:0]    cnt;
  logic [mcst_pkg::CNT_W-1:0]    cnt_m1;
  logic [mcst_pkg::IDX_W-1:0]    proc_idx;
  logic [mcst_pkg::REP_W-1:0]    rep_cnt;
  logic                          pend_valid;
  logic [mcst_pkg::SLOT_W-1:0]   pend_slot;

  // Slot RAM
  mcst_pkg::slot_entry_t         mem [mcst_pkg::TIMERS];
  mcst_pkg::slot_entry_t         mem_rd_data;
  logic                          mem_rd_en;
  logic [mcst_pkg::IDX_W-1:0]    mem_rd_addr;
  logic                          mem_wr_en;
  logic [mcst_pkg::IDX_W-1:0]    mem_wr_addr;
  mcst_pkg::slot_entry_t         mem_wr_data;

  // In-use updates
  logic                          use_set;
  logic                          use_clr;
  logic [mcst_pkg::IDX_W-1:0]    use_idx;

  // Result emission (registered onto the ports)
  logic                          emit;
  logic                          emit_ok;
  logic [mcst_pkg::SLOT_W-1:0]   emit_slot;
  logic                          emit_expired;
  logic [1:0]                    emit_state;
  logic [mcst_pkg::REM_MS_W-1:0] emit_rem_ms;
  logic                          emit_last;
  logic                          pend_load;
  logic [mcst_pkg::SLOT_W-1:0]   pend_slot_next;

  // Decode helpers
  logic                          accept;
  logic                          handle_ok;
  logic [mcst_pkg::SLOT_W-1:0]   handle_m1;
  logic [mcst_pkg::IDX_W-1:0]    hidx;
  logic                          slot_valid;
  logic                          any_free;
  logic [mcst_pkg::IDX_W-1:0]    free_idx;
  logic [mcst_pkg::PER_W-1:0]    per_ticks;
  logic [mcst_pkg::PER_W-1:0]    rem_dec;

  assign busy   = (state != mcst_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign handle_ok  = (handle_reg != '0) &&
                      (handle_reg <= mcst_pkg::SLOT_W'(mcst_pkg::TIMERS));
  assign handle_m1  = handle_reg - 1'b1;
  assign hidx       = handle_m1[mcst_pkg::IDX_W-1:0];
  assign slot_valid = handle_ok && in_use[hidx];
  assign per_ticks  = div_prod[mcst_pkg::REC_SH +: mcst_pkg::PER_W];

  assign cnt_m1   = cnt - 1'b1;
  assign proc_idx = cnt_m1[mcst_pkg::IDX_W-1:0];

  // Partial product of the dividend with one half of the constant reciprocal
  assign div_coef = div_phase ? mcst_pkg::REC_LO : mcst_pkg::REC_HI;
  assign div_part = mcst_pkg::PART_W'(div_x) * mcst_pkg::PART_W'(div_coef);

  // Lowest free slot
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = mcst_pkg::TIMERS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        any_free = 1'b1;
        free_idx = mcst_pkg::IDX_W'(i);
      end
    end
  end

  // Decrement saturates at zero: a zero-period slot expires every tick.
  assign rem_dec = (mem_rd_data.remaining != '0) ? (mem_rd_data.remaining - 1'b1)
                                                 : '0;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      mcst_pkg::ST_IDLE: begin
        if (accept) begin
          if (mcst_pkg::op_t'(operation) == mcst_pkg::OP_TICK) begin
            state_next = mcst_pkg::ST_TICK_SCAN;
          end else if (mcst_pkg::op_t'(operation) == mcst_pkg::OP_CREATE ||
                       mcst_pkg::op_t'(operation) == mcst_pkg::OP_SET_PERIOD) begin
            state_next = mcst_pkg::ST_DIV;
          end else begin
            state_next = mcst_pkg::ST_SLOT_RD;
          end
        end
      end
      mcst_pkg::ST_DIV: begin
        if (div_phase) begin
          state_next = mcst_pkg::ST_SLOT_RD;
        end
      end
      mcst_pkg::ST_SLOT_RD:   state_next = mcst_pkg::ST_SLOT_OP;
      mcst_pkg::ST_SLOT_OP:   state_next = mcst_pkg::ST_IDLE;
      mcst_pkg::ST_TICK_SCAN: begin
        if (cnt == mcst_pkg::CNT_W'(mcst_pkg::TIMERS)) begin
          state_next = mcst_pkg::ST_TICK_DONE;
        end
      end
      mcst_pkg::ST_TICK_DONE: state_next = mcst_pkg::ST_IDLE;
      default:                state_next = mcst_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs of the FSM: RAM access, in-use updates, result emission
  // ---------------------------------------------------------------------------
  always_comb begin
    mem_rd_en      = 1'b0;
    mem_rd_addr    = hidx;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = hidx;
    mem_wr_data    = mem_rd_data;
    use_set        = 1'b0;
    use_clr        = 1'b0;
    use_idx        = hidx;
    emit           = 1'b0;
    emit_ok        = 1'b0;
    emit_slot      = '0;
    emit_expired   = 1'b0;
    emit_state     = mcst_pkg::RS_STOPPED;
    emit_rem_ms    = '0;
    emit_last      = 1'b1;
    pend_load      = 1'b0;
    pend_slot_next = mcst_pkg::SLOT_W'(proc_idx) + 1'b1;

    case (state)
      mcst_pkg::ST_SLOT_RD: begin
        mem_rd_en = 1'b1;
      end

      mcst_pkg::ST_SLOT_OP: begin
        emit = 1'b1;
        case (op_reg)
          mcst_pkg::OP_CREATE: begin
            // Fresh slot: stopped, remaining loaded with the period
            emit_ok                = any_free;
            emit_slot              = any_free ? (mcst_pkg::SLOT_W'(free_idx) + 1'b1) : '0;
            mem_wr_en              = any_free;
            mem_wr_addr            = free_idx;
            mem_wr_data.mode       = mode_reg;
            mem_wr_data.run_state  = mcst_pkg::RS_STOPPED;
            mem_wr_data.period     = per_ticks;
            mem_wr_data.remaining  = per_ticks;
            use_set                = any_free;
            use_idx                = free_idx;
          end
          mcst_pkg::OP_DESTROY: begin
            emit_ok               = slot_valid;
            mem_wr_en             = slot_valid;
            mem_wr_data.run_state = mcst_pkg::RS_STOPPED;
            use_clr               = slot_valid;
          end
          mcst_pkg::OP_START: begin
            emit_ok               = slot_valid;
            mem_wr_en             = slot_valid;
            mem_wr_data.remaining = mem_rd_data.period;
            mem_wr_data.run_state = mcst_pkg::RS_RUNNING;
          end
          mcst_pkg::OP_STOP: begin
            emit_ok               = slot_valid;
            mem_wr_en             = slot_valid;
            mem_wr_data.remaining = '0;
            mem_wr_data.run_state = mcst_pkg::RS_STOPPED;
          end
          mcst_pkg::OP_PAUSE: begin
            emit_ok               = slot_valid &&
                                    (mem_rd_data.run_state == mcst_pkg::RS_RUNNING);
            mem_wr_en             = emit_ok;
            mem_wr_data.run_state = mcst_pkg::RS_PAUSED;
          end
          mcst_pkg::OP_RESUME: begin
            emit_ok               = slot_valid &&
                                    (mem_rd_data.run_state == mcst_pkg::RS_PAUSED);
            mem_wr_en             = emit_ok;
            mem_wr_data.run_state = mcst_pkg::RS_RUNNING;
          end
          mcst_pkg::OP_SET_PERIOD: begin
            // Reload only a running slot
            emit_ok            = slot_valid;
            mem_wr_en          = slot_valid;
            mem_wr_data.period = per_ticks;
            if (mem_rd_data.run_state == mcst_pkg::RS_RUNNING) begin
              mem_wr_data.remaining = per_ticks;
            end
          end
          mcst_pkg::OP_GET_STATE: begin
            emit_ok    = slot_valid;
            emit_state = slot_valid ? mem_rd_data.run_state : mcst_pkg::RS_STOPPED;
          end
          mcst_pkg::OP_GET_REMAINING: begin
            emit_ok     = slot_valid;
            emit_rem_ms = slot_valid ?
                          (mcst_pkg::REM_MS_W'(mem_rd_data.remaining) *
                           mcst_pkg::REM_MS_W'(mcst_pkg::TICK_MS)) : '0;
          end
          mcst_pkg::OP_GET_TICKS: begin
            emit_ok = 1'b1;
          end
          default: begin
            emit_ok = 1'b0;
          end
        endcase
      end

      mcst_pkg::ST_TICK_SCAN: begin
        // Issue the read for slot cnt, process the slot read last cycle
        mem_rd_en   = (cnt < mcst_pkg::CNT_W'(mcst_pkg::TIMERS));
        mem_rd_addr = cnt[mcst_pkg::IDX_W-1:0];
        mem_wr_addr = proc_idx;
        if (cnt != '0 && in_use[proc_idx] &&
            mem_rd_data.run_state == mcst_pkg::RS_RUNNING) begin
          mem_wr_en             = 1'b1;
          mem_wr_data.remaining = rem_dec;
          if (rem_dec == '0) begin
            if (mem_rd_data.mode) begin
              mem_wr_data.remaining = mem_rd_data.period;
            end else begin
              mem_wr_data.run_state = mcst_pkg::RS_STOPPED;
            end
            if (rep_cnt < mcst_pkg::REP_W'(mcst_pkg::MAX_RESULTS)) begin
              // Hold this expiry; release the one held before, not last
              pend_load    = 1'b1;
              emit         = pend_valid;
              emit_ok      = 1'b1;
              emit_slot    = pend_slot;
              emit_expired = 1'b1;
              emit_last    = 1'b0;
            end
          end
        end
      end

      mcst_pkg::ST_TICK_DONE: begin
        emit         = 1'b1;
        emit_ok      = 1'b1;
        emit_slot    = pend_valid ? pend_slot : '0;
        emit_expired = pend_valid;
        emit_last    = 1'b1;
      end

      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Slot RAM: one write, one registered read per cycle
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      mem_rd_data <= mem[mem_rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Control and datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mcst_pkg::ST_IDLE;
      in_use     <= '0;
      tick_count <= '0;
      done       <= 1'b0;
      pend_valid <= 1'b0;
      rep_cnt    <= '0;
      cnt        <= '0;
      div_phase  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= emit;

      if (accept) begin
        op_reg     <= mcst_pkg::op_t'(operation);
        handle_reg <= handle;
        mode_reg   <= mode;
        cnt        <= '0;
        rep_cnt    <= '0;
        pend_valid <= 1'b0;
        div_phase  <= 1'b0;
        div_x      <= mcst_pkg::DIVD_W'(interval_ms) +
                      mcst_pkg::DIVD_W'(mcst_pkg::TICK_MS - 1);
        if (mcst_pkg::op_t'(operation) == mcst_pkg::OP_TICK) begin
          tick_count <= tick_count + 1'b1;
        end
      end

      if (state == mcst_pkg::ST_DIV) begin
        div_phase <= 1'b1;
        if (div_phase) begin
          div_prod <= (div_prod << mcst_pkg::REC_HALF) + mcst_pkg::PROD_W'(div_part);
        end else begin
          div_prod <= mcst_pkg::PROD_W'(div_part);
        end
      end

      if (state == mcst_pkg::ST_TICK_SCAN) begin
        cnt <= cnt + 1'b1;
      end

      if (pend_load) begin
        pend_valid <= 1'b1;
        pend_slot  <= pend_slot_next;
        rep_cnt    <= rep_cnt + 1'b1;
      end

      if (use_set) begin
        in_use[use_idx] <= 1'b1;
      end
      if (use_clr) begin
        in_use[use_idx] <= 1'b0;
      end
    end

    // Result payload: no reset needed
    if (emit) begin
      ok           <= emit_ok;
      slot         <= emit_slot;
      expired      <= emit_expired;
      timer_state  <= emit_state;
      remaining_ms <= emit_rem_ms;
      tick_total   <= tick_count;
      last         <= emit_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == mcst_pkg::ST_IDLE) |-> !mem_wr_en)
    else $error("slot RAM written while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted transaction did not raise busy");

  a_mid_result_in_tick: assert property (@(posedge clk) disable iff (rst)
    (emit && !emit_last) |-> (state == mcst_pkg::ST_TICK_SCAN))
    else $error("non-final result outside a tick scan");

  a_expiry_ok: assert property (@(posedge clk) disable iff (rst)
    (done && expired) |-> (ok && slot != '0))
    else $error("expiry result without ok or slot");

  a_rep_bound: assert property (@(posedge clk) disable iff (rst)
    rep_cnt <= mcst_pkg::REP_W'(mcst_pkg::MAX_RESULTS))
    else $error("expiry report count beyond limit");

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for multi_channel_soft_timer_unit: directed and random
// timer-table transactions checked against an in-bench table predictor.
// Depends on mcst_pkg and the unit itself.
module tb;
  import mcst_pkg::*;

  // One result as seen on the output ports while done is high.
  typedef struct packed {
    logic                ok;
    logic [SLOT_W-1:0]   slot;
    logic                expired;
    logic [1:0]          timer_state;
    logic [REM_MS_W-1:0] remaining_ms;
    logic [TICK_W-1:0]   tick_total;
    logic                last;
  } timer_result_t;

  // Shadow copy of the timer table plus the queue of results it predicts.
  // note_command() advances the shadow table for every accepted transaction,
  // check_result() matches each strobed result against the oldest prediction.
  class soft_timer_scoreboard;
    bit                in_use[TIMERS];
    bit                periodic[TIMERS];
    run_state_t        run_st[TIMERS];
    logic [PER_W-1:0]  period_len[TIMERS];
    logic [PER_W-1:0]  remain_ticks[TIMERS];
    logic [TICK_W-1:0] tick_count;
    timer_result_t     pending_results[$];
    int                failures;

    function new();
      for (int i = 0; i < TIMERS; i++) begin
        in_use[i]       = 1'b0;
        periodic[i]     = 1'b0;
        run_st[i]       = RS_STOPPED;
        period_len[i]   = '0;
        remain_ticks[i] = '0;
      end
      tick_count = '0;
      failures   = 0;
    endfunction

    // Round up to whole ticks; the wide sum keeps periods near 2^32 from wrapping.
    function logic [PER_W-1:0] ms_to_ticks(logic [PMS_W-1:0] pms);
      logic [DIVD_W-1:0] sum;
      sum = DIVD_W'(pms) + DIVD_W'(TICK_MS - 1);
      return PER_W'(sum / DIVD_W'(TICK_MS));
    endfunction

    function int find_slot(logic [SLOT_W-1:0] hdl);
      if (hdl == '0 || hdl > SLOT_W'(TIMERS)) return -1;
      if (!in_use[hdl - 1'b1]) return -1;
      return int'(hdl) - 1;
    endfunction

    function void push_result(logic ok_v, logic [SLOT_W-1:0] slot_v, logic exp_v,
                              logic [1:0] st_v, logic [REM_MS_W-1:0] rem_v,
                              logic last_v);
      timer_result_t r;
      r.ok           = ok_v;
      r.slot         = slot_v;
      r.expired      = exp_v;
      r.timer_state  = st_v;
      r.remaining_ms = rem_v;
      r.tick_total   = tick_count;
      r.last         = last_v;
      pending_results.push_back(r);
    endfunction

    function void note_command(logic [OP_W-1:0] op, logic [SLOT_W-1:0] hdl, logic md,
                               logic [PMS_W-1:0] pms);
      int   idx;
      int   fired;
      int   free_idx;
      logic op_ok;
      idx      = find_slot(hdl);
      fired    = 0;
      free_idx = -1;
      op_ok    = 1'b0;
      case (op)
        OP_TICK: begin
          tick_count = tick_count + 1'b1;
          for (int i = 0; i < TIMERS; i++) begin
            if (in_use[i] && run_st[i] == RS_RUNNING) begin
              if (remain_ticks[i] != '0) remain_ticks[i] = remain_ticks[i] - 1'b1;
              if (remain_ticks[i] == '0) begin
                if (periodic[i]) remain_ticks[i] = period_len[i];
                else run_st[i] = RS_STOPPED;
                if (fired < MAX_RESULTS)
                  push_result(1'b1, SLOT_W'(i + 1), 1'b1, RS_STOPPED, '0, 1'b0);
                fired++;
              end
            end
          end
          if (fired == 0) push_result(1'b1, '0, 1'b0, RS_STOPPED, '0, 1'b1);
          else pending_results[pending_results.size() - 1].last = 1'b1;
        end
        OP_CREATE: begin
          for (int i = 0; i < TIMERS; i++)
            if (!in_use[i] && free_idx < 0) free_idx = i;
          if (free_idx >= 0) begin
            in_use[free_idx]       = 1'b1;
            periodic[free_idx]     = md;
            period_len[free_idx]   = ms_to_ticks(pms);
            remain_ticks[free_idx] = period_len[free_idx];
            run_st[free_idx]       = RS_STOPPED;
            push_result(1'b1, SLOT_W'(free_idx + 1), 1'b0, RS_STOPPED, '0, 1'b1);
          end else begin
            push_result(1'b0, '0, 1'b0, RS_STOPPED, '0, 1'b1);
          end
        end
        OP_GET_STATE:
          push_result(idx >= 0, '0, 1'b0, (idx >= 0) ? run_st[idx] : RS_STOPPED, '0, 1'b1);
        OP_GET_REMAINING:
          push_result(idx >= 0, '0, 1'b0, RS_STOPPED,
                      (idx >= 0) ? REM_MS_W'(remain_ticks[idx]) * REM_MS_W'(TICK_MS) : '0,
                      1'b1);
        OP_GET_TICKS:
          push_result(1'b1, '0, 1'b0, RS_STOPPED, '0, 1'b1);
        OP_DESTROY, OP_START, OP_STOP, OP_PAUSE, OP_RESUME, OP_SET_PERIOD: begin
          if (idx >= 0) begin
            case (op)
              OP_DESTROY: begin
                run_st[idx] = RS_STOPPED;
                in_use[idx] = 1'b0;
                op_ok       = 1'b1;
              end
              OP_START: begin
                remain_ticks[idx] = period_len[idx];
                run_st[idx]       = RS_RUNNING;
                op_ok             = 1'b1;
              end
              OP_STOP: begin
                run_st[idx]       = RS_STOPPED;
                remain_ticks[idx] = '0;
                op_ok             = 1'b1;
              end
              OP_PAUSE: begin
                if (run_st[idx] == RS_RUNNING) begin
                  run_st[idx] = RS_PAUSED;
                  op_ok       = 1'b1;
                end
              end
              OP_RESUME: begin
                if (run_st[idx] == RS_PAUSED) begin
                  run_st[idx] = RS_RUNNING;
                  op_ok       = 1'b1;
                end
              end
              default: begin
                period_len[idx] = ms_to_ticks(pms);
                if (run_st[idx] == RS_RUNNING) remain_ticks[idx] = period_len[idx];
                op_ok = 1'b1;
              end
            endcase
          end
          push_result(op_ok, '0, 1'b0, RS_STOPPED, '0, 1'b1);
        end
        default:
          push_result(1'b0, '0, 1'b0, RS_STOPPED, '0, 1'b1);
      endcase
    endfunction

    function void compare_field(string name, logic [REM_MS_W-1:0] want,
                                logic [REM_MS_W-1:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(timer_result_t got);
      timer_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: slot %0d expired %0b ok %0b", got.slot, got.expired,
               got.ok);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("ok", want.ok, got.ok);
      compare_field("slot", want.slot, got.slot);
      compare_field("expired", want.expired, got.expired);
      compare_field("timer_state", want.timer_state, got.timer_state);
      compare_field("remaining_ms", want.remaining_ms, got.remaining_ms);
      compare_field("tick_total", want.tick_total, got.tick_total);
      compare_field("last", want.last, got.last);
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void flush_leftovers();
      if (pending_results.size() != 0) begin
        $error("%0d predicted results never arrived", pending_results.size());
        failures += pending_results.size();
      end
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [OP_W-1:0]     operation = '0;
  logic [SLOT_W-1:0]   handle = '0;
  logic                mode = 1'b0;
  logic [PMS_W-1:0]    interval_ms = '0;
  logic                busy;
  logic                done;
  logic                ok;
  logic [SLOT_W-1:0]   slot;
  logic                expired;
  logic [1:0]          timer_state;
  logic [REM_MS_W-1:0] remaining_ms;
  logic [TICK_W-1:0]   tick_total;
  logic                last;

  soft_timer_scoreboard sb;
  int cmds_sent    = 0;
  int no_idle_left = 0;

  multi_channel_soft_timer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .handle       (handle),
    .mode         (mode),
    .interval_ms  (interval_ms),
    .done         (done),
    .ok           (ok),
    .slot         (slot),
    .expired      (expired),
    .timer_state  (timer_state),
    .remaining_ms (remaining_ms),
    .tick_total   (tick_total),
    .last         (last)
  );

  // 10 ns clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the unit hangs or never drops busy.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // Capture every strobed result at the edge that ends its cycle; the unit
  // cannot be stalled, so there is nothing to hand back.
  always @(posedge clk) begin : result_monitor
    timer_result_t seen;
    if (!rst && done) begin
      seen.ok           = ok;
      seen.slot         = slot;
      seen.expired      = expired;
      seen.timer_state  = timer_state;
      seen.remaining_ms = remaining_ms;
      seen.tick_total   = tick_total;
      seen.last         = last;
      sb.check_result(seen);
    end
  end

  // Present one transaction and hold it until the unit takes it. An idle gap
  // of random length goes in front, unless a no-idle stretch is running.
  // start stays high straight into the next transaction when there is no gap,
  // so it is never lowered and raised within one edge.
  task automatic issue_command(logic [OP_W-1:0] op, logic [SLOT_W-1:0] hdl, logic md,
                               logic [PMS_W-1:0] pms);
    int gap;
    int pick;
    if (no_idle_left > 0) begin
      gap = 0;
      no_idle_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55) gap = 0;
      else if (pick < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operation   <= op;
    handle      <= hdl;
    mode        <= md;
    interval_ms <= pms;
    start       <= 1'b1;
    // Accepted at the first edge that sees busy low with start high.
    do @(posedge clk); while (busy);
    sb.note_command(op, hdl, md, pms);
    cmds_sent++;
  endtask

  initial begin
    int               waited;
    int               pick;
    logic [OP_W-1:0]  op;
    logic [SLOT_W-1:0] hdl;
    logic [PMS_W-1:0] pms;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, extremes of period and handle, every operation,
    // state-dependent failures, zero period and unknown operations.
    issue_command(OP_GET_TICKS, '0, 1'b0, '0);
    issue_command(OP_TICK, '0, 1'b0, '0);              // tick with nothing running
    issue_command(OP_CREATE, '0, 1'b0, 32'd0);         // one-shot, zero period
    issue_command(OP_CREATE, '0, 1'b1, 32'd1);         // periodic, rounds up to 1 tick
    issue_command(OP_CREATE, '0, 1'b1, 32'hFFFF_FFFF); // largest period, no wrap
    issue_command(OP_CREATE, '0, 1'b0, 32'd25);        // rounds up to 3 ticks
    issue_command(OP_GET_REMAINING, 7'd3, 1'b0, '0);
    issue_command(OP_GET_STATE, 7'd127, 1'b0, '0);     // handle far out of range
    issue_command(OP_GET_REMAINING, 7'd0, 1'b0, '0);   // handle zero is invalid
    issue_command(OP_START, 7'd9, 1'b0, '0);           // just past the table
    issue_command(OP_START, 7'd1, 1'b0, '0);
    issue_command(OP_START, 7'd2, 1'b0, '0);
    issue_command(OP_TICK, '0, 1'b0, '0);              // two expiries in one tick
    issue_command(OP_GET_STATE, 7'd1, 1'b0, '0);       // one-shot has stopped
    issue_command(OP_PAUSE, 7'd2, 1'b0, '0);
    issue_command(OP_PAUSE, 7'd2, 1'b0, '0);           // pause while not running
    issue_command(OP_TICK, '0, 1'b0, '0);
    issue_command(OP_RESUME, 7'd2, 1'b0, '0);
    issue_command(OP_RESUME, 7'd2, 1'b0, '0);          // resume while not paused
    issue_command(OP_SET_PERIOD, 7'd2, 1'b0, 32'd30);  // reloads since running
    issue_command(OP_GET_REMAINING, 7'd2, 1'b0, '0);
    issue_command(OP_STOP, 7'd2, 1'b0, '0);
    issue_command(OP_DESTROY, 7'd4, 1'b0, '0);
    issue_command(OP_DESTROY, 7'd4, 1'b0, '0);         // already freed
    issue_command(4'd15, 7'd64, 1'b1, '0);             // unknown operation

    // Random: mostly single commands on valid handles with short periods so
    // timers really expire; now and then fill the table, start every slot
    // and tick, which also forces a create on a full table.
    while (cmds_sent < 180) begin
      if ($urandom_range(0, 24) == 0) no_idle_left = $urandom_range(10, 30);
      if ($urandom_range(0, 19) == 0) begin
        for (int i = 0; i <= TIMERS; i++)
          issue_command(OP_CREATE, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                        32'($urandom_range(0, 30)));
        for (int h = 1; h <= TIMERS; h++)
          issue_command(OP_START, 7'(h), 1'b0, '0);
        repeat ($urandom_range(1, 4)) issue_command(OP_TICK, '0, 1'b0, '0);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 28) op = OP_TICK;
        else if (pick < 40) op = OP_CREATE;
        else if (pick < 54) op = OP_START;
        else if (pick < 60) op = OP_DESTROY;
        else if (pick < 66) op = OP_STOP;
        else if (pick < 73) op = OP_PAUSE;
        else if (pick < 80) op = OP_RESUME;
        else if (pick < 86) op = OP_SET_PERIOD;
        else if (pick < 91) op = OP_GET_STATE;
        else if (pick < 96) op = OP_GET_REMAINING;
        else if (pick < 98) op = OP_GET_TICKS;
        else op = 4'($urandom_range(11, 15));
        if ($urandom_range(0, 99) < 85) hdl = 7'($urandom_range(1, TIMERS));
        else hdl = 7'($urandom_range(0, 127));
        pick = $urandom_range(0, 9);
        if (pick < 7) pms = 32'($urandom_range(0, 60));
        else if (pick < 9) pms = $urandom;
        else begin
          case ($urandom_range(0, 3))
            0:       pms = 32'h0000_0000;
            1:       pms = 32'hFFFF_FFFF;
            2:       pms = 32'hFFFF_FFF7;
            default: pms = 32'h7FFF_FFFF;
          endcase
        end
        issue_command(op, hdl, 1'($urandom_range(0, 1)), pms);
      end
    end
    // Same edge as the last acceptance: drop start once.
    start <= 1'b0;

    // Drain: wait for every predicted result, then a tick's worth of slack
    // to catch anything extra.
    waited = 0;
    while (sb.outstanding() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (TIMERS + 40) @(posedge clk);
    sb.flush_leftovers();
    if (sb.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
